// File: design/cvs_pkg.sv
// Shared constants, codes and sequencer states of the champion vote scorer.
`default_nettype none

package cvs_pkg;

  // Sizing
  localparam int MAX_CANDIDATES = 1024;
  localparam int MAX_LIST       = 64;
  localparam int SCORE_WIDTH    = 16;
  localparam int ID_W           = 10;
  localparam int CAND_AW        = $clog2(MAX_CANDIDATES);
  localparam int LIST_AW        = (MAX_LIST > 1) ? $clog2(MAX_LIST) : 1;
  localparam int CNT_W          = $clog2(MAX_LIST + 1);

  // Configuration port
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 10;
  localparam logic [CFG_IDX_W-1:0] CFG_LAST_VALID = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LAST_CHAMP = 1'd1;

  // Operation codes
  localparam logic OP_CLEAR = 1'b0;
  localparam logic OP_ENTRY = 1'b1;

  // Sequencer states
  typedef enum logic [2:0] {
    S_INIT,
    S_CLEAR,
    S_IDLE,
    S_INC,
    S_RB_LIST,
    S_RB_READ,
    S_RB_WRITE,
    S_RESULT
  } cvs_state_t;

endpackage

`default_nettype wire

// File: design/champion_vote_scorer.sv
// Top level of the champion vote scorer: sequencer, score memory and list buffer.
//
// Input words arrive on in_valid/in_ready, one result word per input word leaves on
// out_valid/out_ready. The user writes the register file through cfg_write, cfg_index
// and cfg_data only while the block is idle; the block itself does not enforce this.
// A list entry reads its score in the cycle it is accepted and writes it back in the
// next cycle, in S_INC. Its result is loaded in S_INC, or in S_RESULT while the
// output register is full. A skipped entry goes straight to S_RESULT. A champion hit
// walks the buffered list through the single score memory port, passing S_RB_LIST,
// S_RB_READ and S_RB_WRITE for each buffered entry, then S_RESULT. A clear word sweeps
// the score memory one entry a cycle, then goes to S_RESULT.
// In each case in_ready returns in the cycle after the result is loaded.
// in_ready is high only while the sequencer is idle; one word is at work at a time.
// After reset the same sweep runs over MAX_CANDIDATES entries (1024), in_ready low;
// configuration writes are taken throughout.
// The result sits in an output register: the next word is accepted while it waits.
// If the receiver stalls, a finished word holds in the sequencer until the output
// register frees.
`default_nettype none

module champion_vote_scorer
  import cvs_pkg::*;
(
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    cfg_write,
  input  wire [CFG_IDX_W-1:0]    cfg_index,
  input  wire [CFG_DAT_W-1:0]    cfg_data,
  input  wire                    in_valid,
  output logic                   in_ready,
  input  wire                    operation,
  input  wire                    new_list,
  input  wire                    slot_found,
  input  wire [ID_W-1:0]         candidate,
  output logic                   out_valid,
  input  wire                    out_ready,
  output logic                   best_valid,
  output logic [ID_W-1:0]        best_id,
  output logic [SCORE_WIDTH-1:0] best_score,
  output logic                   mark_found
);

  // Configuration registers
  logic              last_valid;
  logic [ID_W-1:0]   last_champ;

  // Control state
  cvs_state_t        state, state_next;
  logic [CAND_AW-1:0] sweep_addr;
  logic [CNT_W-1:0]  list_count;
  logic [CNT_W-1:0]  rb_idx;
  logic              skip_rest;
  logic              best_present;
  logic [CAND_AW-1:0] best_index;
  logic [SCORE_WIDTH-1:0] best_sc;
  logic              hit_found;

  // Payload registers
  logic [CAND_AW-1:0] entry_id;
  logic [CAND_AW-1:0] rb_cand;

  // Memories
  logic [SCORE_WIDTH-1:0] score_mem [MAX_CANDIDATES];
  logic [SCORE_WIDTH-1:0] mem_rdata;
  logic [CAND_AW-1:0]     list_mem [MAX_LIST];
  logic [CAND_AW-1:0]     list_q;

  // Memory port controls
  logic                   mem_we;
  logic [CAND_AW-1:0]     mem_waddr;
  logic [SCORE_WIDTH-1:0] mem_wdata;
  logic [CAND_AW-1:0]     mem_raddr;
  logic                   out_load;

  // Accept-time decode
  logic               in_fire;
  logic               is_entry;
  logic               skip_eff;
  logic [CNT_W-1:0]   count_eff;
  logic [CAND_AW-1:0] cand_id;
  logic               champ_hit;
  logic               out_free;
  logic               sweep_last;
  logic               rb_last;

  // Best update during an entry write-back
  logic [SCORE_WIDTH-1:0] inc_score;
  logic                   bp_next;
  logic [CAND_AW-1:0]     bi_next;
  logic [SCORE_WIDTH-1:0] bs_next;

  assign in_ready   = (state == S_IDLE);
  assign in_fire    = in_valid && in_ready;
  assign is_entry   = (operation == OP_ENTRY);
  assign skip_eff   = new_list ? slot_found : (skip_rest || slot_found);
  assign count_eff  = new_list ? '0 : list_count;
  assign cand_id    = candidate[CAND_AW-1:0];
  assign champ_hit  = last_valid && (cand_id == last_champ[CAND_AW-1:0]);
  assign out_free   = !out_valid || out_ready;
  assign sweep_last = (sweep_addr == CAND_AW'(MAX_CANDIDATES - 1));
  assign rb_last    = ((rb_idx + 1'b1) == list_count);
  assign inc_score  = mem_rdata + 1'b1;

  // Work out the best after this entry's increment
  always_comb begin
    bp_next = best_present;
    bi_next = best_index;
    bs_next = best_sc;
    if (state == S_INC) begin
      if (best_present && (entry_id == best_index)) begin
        bs_next = inc_score;
      end else if (!best_present || (inc_score > best_sc)) begin
        bp_next = 1'b1;
        bi_next = entry_id;
        bs_next = inc_score;
      end
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_INIT: begin
        if (sweep_last) state_next = S_IDLE;
      end
      S_CLEAR: begin
        if (sweep_last) state_next = S_RESULT;
      end
      S_IDLE: begin
        if (in_fire) begin
          if (!is_entry) begin
            state_next = S_CLEAR;
          end else if (skip_eff) begin
            state_next = S_RESULT;
          end else if (champ_hit) begin
            state_next = (count_eff == '0) ? S_RESULT : S_RB_LIST;
          end else begin
            state_next = S_INC;
          end
        end
      end
      S_INC: begin
        state_next = out_free ? S_IDLE : S_RESULT;
      end
      S_RB_LIST:  state_next = S_RB_READ;
      S_RB_READ:  state_next = S_RB_WRITE;
      S_RB_WRITE: begin
        state_next = rb_last ? S_RESULT : S_RB_LIST;
      end
      S_RESULT: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_INIT;
    endcase
  end

  // Memory port and output register controls
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = sweep_addr;
    mem_wdata = '0;
    mem_raddr = cand_id;
    out_load  = 1'b0;
    unique case (state)
      S_INIT, S_CLEAR: begin
        mem_we = 1'b1;
      end
      S_INC: begin
        mem_we    = 1'b1;
        mem_waddr = entry_id;
        mem_wdata = inc_score;
        out_load  = out_free;
      end
      S_RB_READ: begin
        mem_raddr = list_q;
      end
      S_RB_WRITE: begin
        mem_we    = 1'b1;
        mem_waddr = rb_cand;
        mem_wdata = mem_rdata - 1'b1;
      end
      S_RESULT: begin
        out_load = out_free;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // Score memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) score_mem[mem_waddr] <= mem_wdata;
    mem_rdata <= score_mem[mem_raddr];
  end

  // List buffer: written on each counted entry, read during rollback
  always_ff @(posedge clk) begin
    if (in_fire && is_entry && !skip_eff && !champ_hit &&
        (count_eff < CNT_W'(MAX_LIST))) begin
      list_mem[count_eff[LIST_AW-1:0]] <= cand_id;
    end
    list_q <= list_mem[rb_idx[LIST_AW-1:0]];
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      last_valid <= 1'b0;
      last_champ <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_LAST_VALID: last_valid <= cfg_data[0];
        CFG_LAST_CHAMP: last_champ <= cfg_data[ID_W-1:0];
        default:        last_valid <= last_valid;
      endcase
    end
  end

  // Sequencer and scoring state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_INIT;
      sweep_addr   <= '0;
      list_count   <= '0;
      rb_idx       <= '0;
      skip_rest    <= 1'b0;
      best_present <= 1'b0;
      best_index   <= '0;
      best_sc      <= '0;
      hit_found    <= 1'b0;
    end else begin
      state <= state_next;

      // Advance the clearing sweep
      if ((state == S_INIT) || (state == S_CLEAR)) begin
        sweep_addr <= sweep_last ? '0 : sweep_addr + 1'b1;
      end

      // Decode an accepted word
      if (in_fire) begin
        hit_found <= 1'b0;
        rb_idx    <= '0;
        if (!is_entry) begin
          list_count   <= '0;
          skip_rest    <= 1'b0;
          best_present <= 1'b0;
          best_index   <= '0;
          best_sc      <= '0;
        end else begin
          list_count <= count_eff;
          skip_rest  <= skip_eff;
          if (!skip_eff) begin
            if (champ_hit) begin
              skip_rest <= 1'b1;
              hit_found <= 1'b1;
            end else if (count_eff < CNT_W'(MAX_LIST)) begin
              list_count <= count_eff + 1'b1;
            end
          end
        end
      end

      // Commit the best after the increment
      if (state == S_INC) begin
        best_present <= bp_next;
        best_index   <= bi_next;
        best_sc      <= bs_next;
      end

      // Take one back from the best if the rollback touches it
      if (state == S_RB_WRITE) begin
        rb_idx <= rb_idx + 1'b1;
        if (best_present && (rb_cand == best_index)) begin
          best_sc <= best_sc - 1'b1;
        end
      end
    end
  end

  // Hold the entry and rollback candidate ids
  always_ff @(posedge clk) begin
    if (in_fire) entry_id <= cand_id;
    if (state == S_RB_READ) rb_cand <= list_q;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      best_valid <= bp_next;
      best_id    <= ID_W'(bi_next);
      best_score <= bs_next;
      mark_found <= hit_found;
    end
  end

  // Checks
  a_clear_sweeps: assert property (@(posedge clk) disable iff (rst)
    (in_fire && !is_entry) |=> (state == S_CLEAR && !best_present))
    else $error("clear word did not start the sweep");

  a_hit_reported: assert property (@(posedge clk) disable iff (rst)
    (in_fire && is_entry && !skip_eff && champ_hit) |=> (hit_found && skip_rest))
    else $error("champion hit not recorded");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    list_count <= CNT_W'(MAX_LIST))
    else $error("list count beyond buffer depth");

  a_no_best_zero: assert property (@(posedge clk) disable iff (rst)
    !best_present |-> (best_sc == '0 && best_index == '0))
    else $error("forgotten best still carries a value");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    out_load |-> (!out_valid || out_ready))
    else $error("result loaded over a waiting word");

endmodule

`default_nettype wire
